/* design/pal_pkg.sv */
// Shared types, widths and codes of the positional array list.
// Depends on nothing; every other file of the block uses it.
package pal_pkg;

   localparam int CAPACITY = 16;

   // Fixed field widths of the item channels.
   localparam int OP_W     = 2;
   localparam int WORD_W   = 32;
   localparam int POS_W    = 5;
   localparam int STATUS_W = 2;
   localparam int ECOUNT_W = 5;

   // Widths that follow from the capacity.
   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
   localparam logic [OP_W-1:0] OP_LIST   = 2'd2;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE   = 2'd0,
      ST_FULL   = 2'd1,
      ST_BADPOS = 2'd2,
      ST_ENTRY  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_INS,
      S_DEL,
      S_LRD,
      S_LOUT,
      S_RESP
   } seq_state_type;

   typedef struct packed {
      logic                     wr_en;
      logic [IDX_W-1:0]         wr_addr;
      logic signed [WORD_W-1:0] wr_data;
      logic                     rd_en;
      logic [IDX_W-1:0]         rd_addr;
   } mem_req_type;

   typedef struct packed {
      logic                     valid;
      status_type               status;
      logic signed [WORD_W-1:0] entry;
      logic [ECOUNT_W-1:0]      entry_count;
      logic                     last;
   } result_type;

endpackage

/* design/pal_req_if.sv */
// Request channel of the positional array list: handshake and item fields.
// Depends on pal_pkg for the field widths.
interface pal_req_if;
   logic                              valid;
   logic                              ready;
   logic [pal_pkg::OP_W-1:0]          operation;
   logic signed [pal_pkg::WORD_W-1:0] value;
   logic [pal_pkg::POS_W-1:0]         position;

   modport source (output valid, output operation, output value, output position,
                   input ready);
   modport sink   (input valid, input operation, input value, input position,
                   output ready);
endinterface

/* design/pal_rsp_if.sv */
// Response channel of the positional array list: handshake and result fields.
// Depends on pal_pkg for the field widths.
interface pal_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [pal_pkg::STATUS_W-1:0]      status;
   logic signed [pal_pkg::WORD_W-1:0] entry;
   logic [pal_pkg::ECOUNT_W-1:0]      entry_count;
   logic                              last;

   modport source (output valid, output status, output entry, output entry_count,
                   output last, input ready);
   modport sink   (input valid, input status, input entry, input entry_count,
                   input last, output ready);
endinterface

/* design/pal_store.sv */
// Entry memory of the positional array list: one write and one read port,
// read data registered. Depends on pal_pkg.
module pal_store (
   input  logic                              clock,
   input  pal_pkg::mem_req_type              mem_req,
   output logic signed [pal_pkg::WORD_W-1:0] rd_data
);

   logic signed [pal_pkg::WORD_W-1:0] mem [pal_pkg::CAPACITY];
   logic signed [pal_pkg::WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/pal_seq.sv */
// Sequencer of the positional array list: decodes items, keeps the count and
// walks the entry memory for shifts and listing. Depends on pal_pkg.
module pal_seq (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [pal_pkg::OP_W-1:0]          req_operation,
   input  logic signed [pal_pkg::WORD_W-1:0] req_value,
   input  logic [pal_pkg::POS_W-1:0]         req_position,
   output pal_pkg::mem_req_type              mem_req,
   input  logic signed [pal_pkg::WORD_W-1:0] rd_data,
   output pal_pkg::result_type               result,
   input  logic                              out_free
);

   pal_pkg::seq_state_type            state_ff, state_in;
   logic [pal_pkg::CNT_W-1:0]         count_ff, count_in;
   logic [pal_pkg::IDX_W-1:0]         ptr_ff, ptr_in;
   logic [pal_pkg::IDX_W-1:0]         end_ff, end_in;
   logic signed [pal_pkg::WORD_W-1:0] carry_ff, carry_in;
   logic                              issue_ff, issue_in;
   logic                              rd_valid_ff, rd_valid_in;
   logic [pal_pkg::IDX_W-1:0]         rd_addr_ff, rd_addr_in;
   pal_pkg::status_type               status_ff, status_in;

   logic [pal_pkg::CMP_W-1:0] pos_x;
   logic [pal_pkg::CMP_W-1:0] cnt_x;

   assign pos_x = pal_pkg::CMP_W'(req_position);
   assign cnt_x = pal_pkg::CMP_W'(count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= pal_pkg::S_IDLE;
         count_ff    <= '0;
         issue_ff    <= 1'b0;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         issue_ff    <= issue_in;
         rd_valid_ff <= rd_valid_in;
      end
      ptr_ff     <= ptr_in;
      end_ff     <= end_in;
      carry_ff   <= carry_in;
      rd_addr_ff <= rd_addr_in;
      status_ff  <= status_in;
   end

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      ptr_in      = ptr_ff;
      end_in      = end_ff;
      carry_in    = carry_ff;
      issue_in    = issue_ff;
      rd_valid_in = 1'b0;
      rd_addr_in  = rd_addr_ff;
      status_in   = status_ff;
      req_ready   = 1'b0;

      mem_req = '0;

      result.valid       = 1'b0;
      result.status      = status_ff;
      result.entry       = '0;
      result.entry_count = pal_pkg::ECOUNT_W'(count_ff);
      result.last        = 1'b1;

      case (state_ff)
         pal_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in  = pal_pkg::S_RESP;
               status_in = pal_pkg::ST_BADPOS;
               case (req_operation)
                  pal_pkg::OP_INSERT: begin
                     if (count_ff == pal_pkg::CNT_W'(pal_pkg::CAPACITY)) begin
                        status_in = pal_pkg::ST_FULL;
                     end else if (pos_x != '0 &&
                                  pos_x <= cnt_x + pal_pkg::CMP_W'(1)) begin
                        // Walk up from the new position, each entry taking the
                        // one below it; the new word enters as the first carry.
                        ptr_in   = pal_pkg::IDX_W'(pos_x - pal_pkg::CMP_W'(1));
                        end_in   = pal_pkg::IDX_W'(count_ff);
                        carry_in = req_value;
                        issue_in = 1'b1;
                        state_in = pal_pkg::S_INS;
                     end
                  end
                  pal_pkg::OP_DELETE: begin
                     if (pos_x != '0 && pos_x <= cnt_x) begin
                        if (pos_x == cnt_x) begin
                           // Removing the tail moves nothing.
                           count_in  = count_ff - pal_pkg::CNT_W'(1);
                           status_in = pal_pkg::ST_DONE;
                        end else begin
                           ptr_in   = pal_pkg::IDX_W'(pos_x);
                           end_in   = pal_pkg::IDX_W'(count_ff - pal_pkg::CNT_W'(1));
                           issue_in = 1'b1;
                           state_in = pal_pkg::S_DEL;
                        end
                     end
                  end
                  pal_pkg::OP_LIST: begin
                     if (count_ff == '0) begin
                        status_in = pal_pkg::ST_DONE;
                     end else begin
                        ptr_in   = '0;
                        end_in   = pal_pkg::IDX_W'(count_ff - pal_pkg::CNT_W'(1));
                        state_in = pal_pkg::S_LRD;
                     end
                  end
                  default: begin
                     status_in = pal_pkg::ST_BADPOS;
                  end
               endcase
            end
         end

         pal_pkg::S_INS: begin
            mem_req.rd_en   = issue_ff;
            mem_req.rd_addr = ptr_ff;
            rd_valid_in     = issue_ff;
            rd_addr_in      = ptr_ff;
            if (issue_ff) begin
               ptr_in = ptr_ff + pal_pkg::IDX_W'(1);
               if (ptr_ff == end_ff) begin
                  issue_in = 1'b0;
               end
            end
            if (rd_valid_ff) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = rd_addr_ff;
               mem_req.wr_data = carry_ff;
               carry_in        = rd_data;
               if (rd_addr_ff == end_ff) begin
                  count_in  = count_ff + pal_pkg::CNT_W'(1);
                  status_in = pal_pkg::ST_DONE;
                  state_in  = pal_pkg::S_RESP;
               end
            end
         end

         pal_pkg::S_DEL: begin
            mem_req.rd_en   = issue_ff;
            mem_req.rd_addr = ptr_ff;
            rd_valid_in     = issue_ff;
            rd_addr_in      = ptr_ff;
            if (issue_ff) begin
               ptr_in = ptr_ff + pal_pkg::IDX_W'(1);
               if (ptr_ff == end_ff) begin
                  issue_in = 1'b0;
               end
            end
            if (rd_valid_ff) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = rd_addr_ff - pal_pkg::IDX_W'(1);
               mem_req.wr_data = rd_data;
               if (rd_addr_ff == end_ff) begin
                  count_in  = count_ff - pal_pkg::CNT_W'(1);
                  status_in = pal_pkg::ST_DONE;
                  state_in  = pal_pkg::S_RESP;
               end
            end
         end

         pal_pkg::S_LRD: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = ptr_ff;
            state_in        = pal_pkg::S_LOUT;
         end

         pal_pkg::S_LOUT: begin
            // The read data stays put until the next read, so a stalled
            // output simply holds this state.
            result.valid  = 1'b1;
            result.status = pal_pkg::ST_ENTRY;
            result.entry  = rd_data;
            result.last   = (ptr_ff == end_ff);
            if (out_free) begin
               if (ptr_ff == end_ff) begin
                  state_in = pal_pkg::S_IDLE;
               end else begin
                  ptr_in   = ptr_ff + pal_pkg::IDX_W'(1);
                  state_in = pal_pkg::S_LRD;
               end
            end
         end

         pal_pkg::S_RESP: begin
            result.valid = 1'b1;
            if (out_free) begin
               state_in = pal_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = pal_pkg::S_IDLE;
         end
      endcase
   end

endmodule

/* design/pal_out.sv */
// Output register of the positional array list: holds one result item until
// the consumer takes it. Depends on pal_pkg.
module pal_out (
   input  logic                              clock,
   input  logic                              reset,
   input  pal_pkg::result_type               result,
   output logic                              out_free,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [pal_pkg::STATUS_W-1:0]      rsp_status,
   output logic signed [pal_pkg::WORD_W-1:0] rsp_entry,
   output logic [pal_pkg::ECOUNT_W-1:0]      rsp_entry_count,
   output logic                              rsp_last
);

   logic                              valid_ff;
   logic [pal_pkg::STATUS_W-1:0]      status_ff;
   logic signed [pal_pkg::WORD_W-1:0] entry_ff;
   logic [pal_pkg::ECOUNT_W-1:0]      count_ff;
   logic                              last_ff;

   assign out_free = !valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (out_free) begin
         valid_ff <= result.valid;
      end
      if (out_free && result.valid) begin
         status_ff <= result.status;
         entry_ff  <= result.entry;
         count_ff  <= result.entry_count;
         last_ff   <= result.last;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_entry       = entry_ff;
   assign rsp_entry_count = count_ff;
   assign rsp_last        = last_ff;

endmodule

/* design/positional_array_list.sv */
// Top level of the positional array list.
// Depends on pal_pkg, pal_req_if, pal_rsp_if, pal_store, pal_seq and pal_out.

// A bounded ordered list of signed 32-bit words, addressed by 1-based
// position, held in a single synchronous memory of CAPACITY entries with one
// write and one read port and registered read data. An insert at position p
// (1..count+1) or a delete at position p (1..count) answers with one item of
// status done; a full list or a bad position answers at once and changes
// nothing, and so does the meaningless operation code. Each item is worked on
// alone: an insert or a delete shifts the list from position p on, walking
// the memory one entry per cycle through its single read port with the
// registered read ahead of the write; errors, deleting the tail and listing
// an empty list walk no memory. A list answers with one item per stored entry,
// status listed entry, the final one marked last, each entry taking a memory
// read and then a hand-off into the output register, which waits while that
// register is full. The output register lets the block finish an item and take
// the next one while a result still waits to be taken. The memory needs no
// clearing after reset: the one entry read at or above the count, the tail read
// of an insert, is dropped, and each entry below the count has been written.
module positional_array_list (
   input  logic      clock,
   input  logic      reset,
   pal_req_if.sink   req_ch,
   pal_rsp_if.source rsp_ch
);

   pal_pkg::mem_req_type              mem_req;
   logic signed [pal_pkg::WORD_W-1:0] rd_data;
   pal_pkg::result_type               result;
   logic                              out_free;

   // Entry storage.
   pal_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   // Item decode, count keeping and the memory walks for shift and list.
   pal_seq u_seq (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_ch.valid),
      .req_ready     (req_ch.ready),
      .req_operation (req_ch.operation),
      .req_value     (req_ch.value),
      .req_position  (req_ch.position),
      .mem_req       (mem_req),
      .rd_data       (rd_data),
      .result        (result),
      .out_free      (out_free)
   );

   // Result register facing the consumer.
   pal_out u_out (
      .clock           (clock),
      .reset           (reset),
      .result          (result),
      .out_free        (out_free),
      .rsp_valid       (rsp_ch.valid),
      .rsp_ready       (rsp_ch.ready),
      .rsp_status      (rsp_ch.status),
      .rsp_entry       (rsp_ch.entry),
      .rsp_entry_count (rsp_ch.entry_count),
      .rsp_last        (rsp_ch.last)
   );

endmodule

/* dv/tb_top.sv */
// Self-checking testbench for positional_array_list: directed rows, then random
// insert, delete and list items, checked against a list predictor kept in the bench.
// Depends on pal_pkg, pal_req_if, pal_rsp_if and the positional_array_list RTL.
`timescale 1ns / 100ps

module tb_top;
   import pal_pkg::*;

   // The block gives operation code 3 no meaning; it must answer bad position.
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   localparam int N_ROWS         = 26;
   localparam int RANDOM_ITEMS   = 60;
   localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
   localparam int TAIL_CYCLES    = 40;    // quiet time after the last result
   localparam int WATCHDOG_LIMIT = 3000;  // cycles with no item moving on either side
   localparam int REPORT_LIMIT   = 10;

   // One result item as the block should deliver it.
   typedef struct packed {
      status_type               status;
      logic signed [WORD_W-1:0] entry;
      logic [ECOUNT_W-1:0]      entry_count;
      logic                     last;
   } answer_type;

   // One row of the directed part. A fill row expands into inserts at the end
   // of the list until it is full. Rows with typed set carry the single result
   // that can be read straight off the list contents.
   typedef struct {
      logic [OP_W-1:0]          op;
      logic signed [WORD_W-1:0] word;
      logic [POS_W-1:0]         pos;
      bit                       fill;
      bit                       typed;
      status_type               want_status;
      int                       want_count;
   } stim_row_type;

   logic clock;
   logic reset;

   pal_req_if req_bus ();
   pal_rsp_if rsp_bus ();

   positional_array_list uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   // Predictor state: the list contents and its length, as the block should hold them.
   logic signed [WORD_W-1:0] list_words [CAPACITY];
   int                       list_len;

   // Results still owed by the block, oldest first.
   answer_type pending_answers [$];

   int  error_count;
   int  items_sent;
   int  results_seen;
   int  status_hits [4];
   int  burst_left;
   int  quiet_cycles;
   bit  hold_off_req;
   int  hold_offs_done;

   // Directed part. The list contents are noted after each row that changes them.
   stim_row_type directed_rows [N_ROWS] = '{
      //   op         word           pos fill typed status     count
      '{OP_LIST,   32'h0000_0000,  0, 0, 1, ST_DONE,   0},   // list of an empty list
      '{OP_DELETE, 32'h0000_0000,  1, 0, 1, ST_BADPOS, 0},   // delete on an empty list
      '{OP_INSERT, 32'h0000_0005,  0, 0, 1, ST_BADPOS, 0},   // position zero
      '{OP_INSERT, 32'h0000_0005,  2, 0, 1, ST_BADPOS, 0},   // one past count + 1
      '{OP_UNUSED, 32'hFFFF_FFFF, 31, 0, 1, ST_BADPOS, 0},   // meaningless operation
      '{OP_INSERT, 32'h7FFF_FFFF,  1, 0, 1, ST_DONE,   1},   // max
      '{OP_INSERT, 32'h8000_0000,  2, 0, 1, ST_DONE,   2},   // max, min
      '{OP_INSERT, 32'h0000_0000,  1, 0, 1, ST_DONE,   3},   // 0, max, min
      '{OP_INSERT, 32'hFFFF_FFFF,  3, 0, 1, ST_DONE,   4},   // 0, max, -1, min
      '{OP_LIST,   32'h0000_0000,  0, 0, 0, ST_DONE,   0},
      '{OP_DELETE, 32'h0000_0000,  5, 0, 1, ST_BADPOS, 4},   // one past the tail
      '{OP_DELETE, 32'h0000_0000, 31, 0, 1, ST_BADPOS, 4},
      '{OP_DELETE, 32'h0000_0000,  2, 0, 1, ST_DONE,   3},   // 0, -1, min
      '{OP_DELETE, 32'h0000_0000,  3, 0, 1, ST_DONE,   2},   // 0, -1 (tail)
      '{OP_DELETE, 32'h0000_0000,  1, 0, 1, ST_DONE,   1},   // -1 (head)
      '{OP_LIST,   32'h0000_0000,  0, 0, 0, ST_DONE,   0},
      '{OP_INSERT, 32'h0000_0000,  0, 1, 0, ST_DONE,   0},   // load up to capacity
      '{OP_INSERT, 32'h1234_5678,  1, 0, 1, ST_FULL,   16},  // full, good position
      '{OP_INSERT, 32'h1234_5678,  0, 0, 1, ST_FULL,   16},  // full wins over bad position
      '{OP_INSERT, 32'h1234_5678, 31, 0, 1, ST_FULL,   16},
      '{OP_LIST,   32'h0000_0000,  7, 0, 0, ST_DONE,   0},   // longest listing
      '{OP_DELETE, 32'h0000_0000, 17, 0, 1, ST_BADPOS, 16},
      '{OP_DELETE, 32'h0000_0000, 16, 0, 1, ST_DONE,   15},
      '{OP_INSERT, 32'h5A5A_A5A5, 16, 0, 1, ST_DONE,   16},  // insert at the end
      '{OP_DELETE, 32'h0000_0000,  1, 0, 1, ST_DONE,   15},
      '{OP_LIST,   32'h0000_0000, 31, 0, 0, ST_DONE,   0}
   };

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Predictor: applies one accepted item to the list and queues the results
   // it must produce. Inserts check for a full list before the position.
   function automatic void apply_list_op(input logic [OP_W-1:0] op,
                                         input logic signed [WORD_W-1:0] word,
                                         input logic [POS_W-1:0] pos);
      answer_type ans;
      int         p;
      int         k;
      p   = pos;
      ans = '{status: ST_DONE, entry: '0, entry_count: '0, last: 1'b1};
      case (op)
         OP_INSERT: begin
            if (list_len >= CAPACITY) begin
               ans.status = ST_FULL;
            end else if (p < 1 || p > list_len + 1) begin
               ans.status = ST_BADPOS;
            end else begin
               for (k = list_len; k >= p; k--) list_words[k] = list_words[k - 1];
               list_words[p - 1] = word;
               list_len++;
            end
         end
         OP_DELETE: begin
            if (p < 1 || p > list_len) begin
               ans.status = ST_BADPOS;
            end else begin
               for (k = p - 1; k + 1 < list_len; k++) list_words[k] = list_words[k + 1];
               list_len--;
            end
         end
         OP_LIST: begin
            // A non-empty list answers with one item per entry; an empty one
            // falls through to the single done result below.
            if (list_len > 0) begin
               for (k = 0; k < list_len; k++) begin
                  ans.status      = ST_ENTRY;
                  ans.entry       = list_words[k];
                  ans.entry_count = ECOUNT_W'(list_len);
                  ans.last        = (k == list_len - 1);
                  pending_answers.push_back(ans);
               end
               return;
            end
         end
         default: begin
            ans.status = ST_BADPOS;
         end
      endcase
      ans.entry_count = ECOUNT_W'(list_len);
      pending_answers.push_back(ans);
   endfunction

   // Offers one item and returns in the time step of its acceptance. The sender
   // works in bursts: between bursts valid drops for a random gap, and some
   // bursts are long enough to give stretches with no gaps at all.
   task automatic offer_item(input logic [OP_W-1:0] op,
                             input logic signed [WORD_W-1:0] word,
                             input logic [POS_W-1:0] pos,
                             input bit typed,
                             input answer_type typed_ans);
      int gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 8);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_bus.valid     <= 1'b1;
      req_bus.operation <= op;
      req_bus.value     <= word;
      req_bus.position  <= pos;
      do @(posedge clock); while (!req_bus.ready);
      items_sent++;
      apply_list_op(op, word, pos);
      // For rows with a typed result, that result replaces the predicted one.
      if (typed) begin
         void'(pending_answers.pop_back());
         pending_answers.push_back(typed_ans);
      end
   endtask

   // Stops offering and waits until every owed result has been taken.
   task automatic drain_answers();
      req_bus.valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (pending_answers.size() != 0);
   endtask

   task automatic note_error(input string what);
      error_count++;
      if (error_count <= REPORT_LIMIT) $display("mismatch: %s", what);
   endtask

   // Main sequence: reset, directed rows, then random items.
   initial begin : stimulus
      stim_row_type             row;
      answer_type               typed_ans;
      bit                       filling;
      int                       n;
      int                       roll;
      logic [OP_W-1:0]          op;
      logic signed [WORD_W-1:0] word;
      logic [POS_W-1:0]         pos;

      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.operation <= OP_INSERT;
      req_bus.value     <= '0;
      req_bus.position  <= '0;
      list_len          = 0;
      foreach (list_words[k]) list_words[k] = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part.
      foreach (directed_rows[r]) begin
         row = directed_rows[r];
         typed_ans = '{status: row.want_status, entry: '0,
                       entry_count: ECOUNT_W'(row.want_count), last: 1'b1};
         if (row.fill) begin
            while (list_len < CAPACITY)
               offer_item(OP_INSERT, 32'hA5C3_0000 | WORD_W'(list_len),
                          POS_W'(list_len + 1), 1'b0, typed_ans);
         end else begin
            offer_item(row.op, row.word, row.pos, row.typed, typed_ans);
         end
      end
      drain_answers();

      // Random part. Most items are well-formed inserts and deletes whose
      // balance drifts between filling and draining the list, so that it
      // reaches both full and empty; lists are common, and a share of items
      // are noise with any operation code and any position.
      filling = 1'b1;
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 15) hold_off_req = 1'b1;   // receiver goes quiet, block backs up
         if (n == 40) drain_answers();        // sender waits for the block to empty
         roll = $urandom_range(0, 99);
         pos  = POS_W'($urandom_range(0, 31));
         if (roll < 12) begin
            op = OP_W'($urandom_range(0, 3));
         end else if (roll < 24) begin
            op = OP_LIST;
         end else begin
            if (list_len == CAPACITY) filling = 1'b0;
            else if (list_len == 0) filling = 1'b1;
            if (list_len == 0 ||
                (list_len < CAPACITY && (filling == (roll % 4 != 0)))) begin
               op  = OP_INSERT;
               pos = POS_W'($urandom_range(1, list_len + 1));
            end else begin
               op  = OP_DELETE;
               pos = POS_W'($urandom_range(1, list_len));
            end
         end
         case ($urandom_range(0, 7))
            0:       word = 32'h8000_0000;
            1:       word = 32'h7FFF_FFFF;
            2:       word = '0;
            3:       word = '1;
            default: word = $urandom;
         endcase
         offer_item(op, word, pos, 1'b0, typed_ans);
      end

      drain_answers();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Run covered %0d items, %0d results: %0d listed entries, %0d done,",
               items_sent, results_seen, status_hits[ST_ENTRY], status_hits[ST_DONE]);
      $display("%0d list full, %0d bad position, %0d receiver hold-offs, %0d mismatches.",
               status_hits[ST_FULL], status_hits[ST_BADPOS], hold_offs_done, error_count);
      if (error_count == 0) begin
         $display("[positional_array_list] OK");
      end else begin
         $display("[positional_array_list] ERROR");
      end
      $finish;
   end

   // Receiver: ready follows a mode picked for a random stretch of cycles
   // (always ready, coin toss, mostly stalled, or a fixed rhythm). When the
   // sender asks for it, ready stays low for a long hold-off counted here.
   initial begin : receiver
      int mode;
      int phase_left;
      int hold_left;
      rsp_bus.ready <= 1'b0;
      mode       = 0;
      phase_left = 0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_bus.ready <= 1'b0;
            for (hold_left = HOLD_CYCLES; hold_left > 0; hold_left--) @(posedge clock);
            hold_offs_done++;
         end
         if (phase_left == 0) begin
            mode       = $urandom_range(0, 3);
            phase_left = $urandom_range(16, 80);
         end
         phase_left--;
         case (mode)
            0:       rsp_bus.ready <= 1'b1;
            1:       rsp_bus.ready <= $urandom_range(0, 1);
            2:       rsp_bus.ready <= ($urandom_range(0, 3) == 0);
            default: rsp_bus.ready <= (phase_left % 5 != 0);
         endcase
      end
   end

   // Result checker: every accepted result is compared with the oldest
   // expectation, field by field.
   always @(posedge clock) begin : check_results
      answer_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         results_seen++;
         status_hits[rsp_bus.status]++;
         if (pending_answers.size() == 0) begin
            note_error($sformatf("unexpected result status %0d entry %0d count %0d last %0b",
                                 rsp_bus.status, rsp_bus.entry, rsp_bus.entry_count,
                                 rsp_bus.last));
         end else begin
            want = pending_answers.pop_front();
            if (rsp_bus.status !== want.status || rsp_bus.entry !== want.entry ||
                rsp_bus.entry_count !== want.entry_count || rsp_bus.last !== want.last)
               note_error($sformatf({"result %0d: expected status %0d entry %0d count %0d ",
                                     "last %0b, got status %0d entry %0d count %0d last %0b"},
                                    results_seen, want.status, want.entry,
                                    want.entry_count, want.last, rsp_bus.status,
                                    rsp_bus.entry, rsp_bus.entry_count, rsp_bus.last));
         end
      end
   end

   // Watchdog: ends the run if no item moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no item moved for %0d cycles, %0d results still owed",
                  quiet_cycles, pending_answers.size());
         $display("[positional_array_list] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule

/* sim.f */
design/pal_pkg.sv
design/pal_req_if.sv
design/pal_rsp_if.sv
design/pal_store.sv
design/pal_seq.sv
design/pal_out.sv
design/positional_array_list.sv
dv/tb_top.sv
